FILE: hw/rtl/wavhp_pkg.sv
// Shared types and constants for the WAV header parser.
// No dependencies; compiled before the interfaces and modules.
package wavhp_pkg;

  // Little-endian chunk marks as they appear once four bytes are shifted in.
  localparam logic [31:0] MARK_RIFF      = 32'h4646_4952;
  localparam logic [31:0] MARK_WAVE      = 32'h4556_4157;
  localparam logic [31:0] MARK_FMT       = 32'h2074_6d66;
  localparam logic [31:0] MARK_DATA      = 32'h6174_6164;
  localparam logic [31:0] FMT_CHUNK_SIZE = 32'd16;

  localparam logic [15:0] FMT_PCM     = 16'd1;
  localparam logic [15:0] CH_MONO     = 16'd1;
  localparam logic [15:0] CH_STEREO   = 16'd2;
  localparam logic [15:0] BITS_NARROW = 16'd8;
  localparam logic [15:0] BITS_WIDE   = 16'd16;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_ERROR  = 2'd2
  } wavhp_kind_t;

  typedef enum logic [3:0] {
    ERR_NONE       = 4'd0,
    ERR_RIFF       = 4'd1,
    ERR_WAVE       = 4'd2,
    ERR_FMT        = 4'd3,
    ERR_FMT_SIZE   = 4'd4,
    ERR_COMPRESSED = 4'd5,
    ERR_CHANNELS   = 4'd6,
    ERR_BITS       = 4'd7,
    ERR_DATA_MARK  = 4'd8
  } wavhp_err_t;

  typedef struct packed {
    wavhp_kind_t kind;
    wavhp_err_t  error_code;
    logic        stereo;
    logic        sixteen_bit;
    logic [31:0] audio_rate;
    logic [31:0] data_length;
    logic [7:0]  data_byte;
    logic        last_byte;
  } wavhp_result_t;

endpackage

FILE: hw/rtl/wavhp_in_if.sv
// Byte stream channel into the WAV header parser.
// Depends on nothing but the valid/ready convention.
interface wavhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       start_of_file;

  modport source (output valid, output file_byte, output start_of_file, input ready);
  modport sink   (input valid, input file_byte, input start_of_file, output ready);
endinterface

FILE: hw/rtl/wavhp_out_if.sv
// Result channel out of the WAV header parser.
// Field widths follow the result type in wavhp_pkg.
interface wavhp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [3:0]  error_code;
  logic        stereo;
  logic        sixteen_bit;
  logic [31:0] audio_rate;
  logic [31:0] data_length;
  logic [7:0]  data_byte;
  logic        last_byte;

  modport source (output valid, output result_kind, output error_code, output stereo,
                  output sixteen_bit, output audio_rate, output data_length,
                  output data_byte, output last_byte, input ready);
  modport sink   (input valid, input result_kind, input error_code, input stereo,
                  input sixteen_bit, input audio_rate, input data_length,
                  input data_byte, input last_byte, output ready);
endinterface

FILE: hw/rtl/wavhp_out_buf.sv
// Two-entry output register with skid stage for parser results.
// Uses wavhp_result_t from wavhp_pkg.
module wavhp_out_buf import wavhp_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  wavhp_result_t push_item,
  output logic          push_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output wavhp_result_t out_item
);

  logic          out_valid_r, out_valid_nxt;
  logic          skid_valid_r, skid_valid_nxt;
  wavhp_result_t out_item_r, out_item_nxt;
  wavhp_result_t skid_item_r, skid_item_nxt;

  // A push only arrives while the skid stage is empty.
  assign push_ready = !skid_valid_r;
  assign out_valid  = out_valid_r;
  assign out_item   = out_item_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_item_nxt   = out_item_r;
    skid_valid_nxt = skid_valid_r;
    skid_item_nxt  = skid_item_r;
    if (!out_valid_r || out_ready) begin
      out_valid_nxt  = skid_valid_r || push;
      out_item_nxt   = skid_valid_r ? skid_item_r : push_item;
      skid_valid_nxt = 1'b0;
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_item_nxt  = push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_item_r  <= out_item_nxt;
    skid_item_r <= skid_item_nxt;
  end

endmodule

FILE: hw/rtl/wav_header_parser.sv
// Top level of the RIFF/WAVE PCM header parser.
// Depends on wavhp_pkg, wavhp_in_if, wavhp_out_if and wavhp_out_buf.
//
// The parser takes a WAV file one byte per item and checks the canonical
// 44-byte header: the RIFF, WAVE, 'fmt ' and 'data' marks, a format chunk
// size of 16, PCM format, one or two channels and 8 or 16 bits per sample.
// The first failed check gives a single error item and the parser then
// drops bytes until an item arrives with start_of_file set. A good header
// gives one header item (channel mode, sample width, sample rate, data
// length), after which every data byte passes through as a data item with
// the last one marked; bytes beyond the data length are dropped. An item
// with start_of_file set restarts the parse at header byte 0 in any phase.
// One byte is taken every clock cycle while the output buffer has room:
// each byte is handled by a single compare-and-shift step, and its result
// (if any) is registered into the output buffer before it shows on the
// output. A two-entry output buffer lets the input keep flowing while the
// output is stalled; the input only stops once both entries are full.
module wav_header_parser import wavhp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  wavhp_in_if.sink  in_ch,
  wavhp_out_if.source out_ch
);

  // Header byte positions at which a complete field has been shifted in.
  localparam logic [5:0] POS_RIFF     = 6'd3;
  localparam logic [5:0] POS_WAVE     = 6'd11;
  localparam logic [5:0] POS_FMT      = 6'd15;
  localparam logic [5:0] POS_FMT_SIZE = 6'd19;
  localparam logic [5:0] POS_FORMAT   = 6'd21;
  localparam logic [5:0] POS_CHANNELS = 6'd23;
  localparam logic [5:0] POS_RATE     = 6'd27;
  localparam logic [5:0] POS_BITS     = 6'd35;
  localparam logic [5:0] POS_DATA     = 6'd39;
  localparam logic [5:0] POS_LENGTH   = 6'd43;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DATA   = 2'd1,
    PH_IDLE   = 2'd2
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic        stereo_r, stereo_nxt;
  logic        wide_r, wide_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [31:0] remaining_r, remaining_nxt;

  logic          in_fire;
  logic          buf_ready;
  logic          res_valid;
  wavhp_result_t res_item;
  wavhp_result_t out_item;

  // Effective state for this byte: a start mark restarts the header parse.
  phase_t      cur_phase;
  logic [5:0]  cur_pos;
  logic [31:0] shifted;
  logic [15:0] half;
  logic [31:0] remaining_dec;

  assign in_ch.ready = buf_ready;
  assign in_fire     = in_ch.valid && buf_ready;

  assign cur_phase     = in_ch.start_of_file ? PH_HEADER : phase_r;
  assign cur_pos       = in_ch.start_of_file ? 6'd0 : pos_r;
  assign shifted       = {in_ch.file_byte, shift_r[31:8]};
  assign half          = shifted[31:16];
  assign remaining_dec = remaining_r - 32'd1;

  always_comb begin
    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    shift_nxt     = shift_r;
    stereo_nxt    = stereo_r;
    wide_nxt      = wide_r;
    rate_nxt      = rate_r;
    remaining_nxt = remaining_r;
    res_valid     = 1'b0;
    res_item      = '0;
    res_item.kind = KIND_HEADER;
    res_item.error_code = ERR_NONE;

    if (in_fire) begin
      phase_nxt = cur_phase;
      pos_nxt   = cur_pos;
      case (cur_phase)
        PH_DATA: begin
          res_valid          = 1'b1;
          res_item.kind      = KIND_DATA;
          res_item.data_byte = in_ch.file_byte;
          remaining_nxt      = remaining_dec;
          if (remaining_dec == 32'd0) begin
            res_item.last_byte = 1'b1;
            phase_nxt          = PH_IDLE;
          end
        end
        PH_HEADER: begin
          shift_nxt = shifted;
          pos_nxt   = cur_pos + 6'd1;
          case (cur_pos)
            POS_RIFF: begin
              if (shifted != MARK_RIFF) begin
                res_valid           = 1'b1;
                res_item.error_code = ERR_RIFF;
              end
            end
            POS_WAVE: begin
              if (shifted != MARK_WAVE) begin
                res_valid           = 1'b1;
                res_item.error_code = ERR_WAVE;
              end
            end
            POS_FMT: begin
              if (shifted != MARK_FMT) begin
                res_valid           = 1'b1;
                res_item.error_code = ERR_FMT;
              end
            end
            POS_FMT_SIZE: begin
              if (shifted != FMT_CHUNK_SIZE) begin
                res_valid           = 1'b1;
                res_item.error_code = ERR_FMT_SIZE;
              end
            end
            POS_FORMAT: begin
              if (half != FMT_PCM) begin
                res_valid           = 1'b1;
                res_item.error_code = ERR_COMPRESSED;
              end
            end
            POS_CHANNELS: begin
              if (!(half inside {CH_MONO, CH_STEREO})) begin
                res_valid           = 1'b1;
                res_item.error_code = ERR_CHANNELS;
              end else begin
                stereo_nxt = (half == CH_STEREO);
              end
            end
            POS_RATE: begin
              rate_nxt = shifted;
            end
            POS_BITS: begin
              if (!(half inside {BITS_NARROW, BITS_WIDE})) begin
                res_valid           = 1'b1;
                res_item.error_code = ERR_BITS;
              end else begin
                wide_nxt = (half == BITS_WIDE);
              end
            end
            POS_DATA: begin
              if (shifted != MARK_DATA) begin
                res_valid           = 1'b1;
                res_item.error_code = ERR_DATA_MARK;
              end
            end
            POS_LENGTH: begin
              // Header complete: report it, then pass the payload if any.
              res_valid            = 1'b1;
              res_item.kind        = KIND_HEADER;
              res_item.stereo      = stereo_r;
              res_item.sixteen_bit = wide_r;
              res_item.audio_rate  = rate_r;
              res_item.data_length = shifted;
              remaining_nxt        = shifted;
              phase_nxt            = (shifted != 32'd0) ? PH_DATA : PH_IDLE;
            end
            default: begin
            end
          endcase
          // Any check that failed above ends the parse with one error item.
          if (res_item.error_code != ERR_NONE) begin
            res_item.kind = KIND_ERROR;
            phase_nxt     = PH_IDLE;
          end
        end
        default: begin
          // Idle (and the unused phase code): bytes are dropped.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      pos_r   <= 6'd0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
    end
    shift_r     <= shift_nxt;
    stereo_r    <= stereo_nxt;
    wide_r      <= wide_nxt;
    rate_r      <= rate_nxt;
    remaining_r <= remaining_nxt;
  end

  wavhp_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_fire && res_valid),
    .push_item  (res_item),
    .push_ready (buf_ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_item   (out_item)
  );

  assign out_ch.result_kind = out_item.kind;
  assign out_ch.error_code  = out_item.error_code;
  assign out_ch.stereo      = out_item.stereo;
  assign out_ch.sixteen_bit = out_item.sixteen_bit;
  assign out_ch.audio_rate  = out_item.audio_rate;
  assign out_ch.data_length = out_item.data_length;
  assign out_ch.data_byte   = out_item.data_byte;
  assign out_ch.last_byte   = out_item.last_byte;

endmodule
